### hdl/itchp_pkg.sv
// itchp_pkg: constants, types and layout tables for the itch field parser
// no dependencies
`default_nettype none
package itchp_pkg;

   localparam int TYPE_COUNT = 23;
   localparam int TYPE_W = 5;
   localparam int POS_W = 5;

   localparam logic [2:0] ST_FIELD      = 3'd0;
   localparam logic [2:0] ST_UNKNOWN    = 3'd1;
   localparam logic [2:0] ST_INC_HEADER = 3'd2;
   localparam logic [2:0] ST_INC_MSG    = 3'd3;
   localparam logic [2:0] ST_SHORT      = 3'd4;

   localparam logic [1:0] PH_LEN_HI = 2'd0;
   localparam logic [1:0] PH_LEN_LO = 2'd1;
   localparam logic [1:0] PH_TYPE   = 2'd2;
   localparam logic [1:0] PH_BODY   = 2'd3;

   localparam logic [0:0] CFG_FILTER = 1'b0;
   localparam logic [0:0] CFG_MASK   = 1'b1;

   typedef struct packed {
      logic [7:0]  msg_type;
      logic [3:0]  field_index;
      logic [63:0] field_value;
      logic [3:0]  field_bytes;
      logic        last_field;
      logic [2:0]  status;
   } result_type;

   // known type code, TYPE_COUNT when not a known type
   function automatic logic [TYPE_W-1:0] type_lookup(input logic [7:0] b);
      logic [TYPE_W-1:0] c;
      c = TYPE_W'(TYPE_COUNT);
      unique case (b)
         "S": c = 5'd0;   "R": c = 5'd1;   "H": c = 5'd2;   "Y": c = 5'd3;
         "L": c = 5'd4;   "V": c = 5'd5;   "W": c = 5'd6;   "K": c = 5'd7;
         "J": c = 5'd8;   "h": c = 5'd9;   "A": c = 5'd10;  "F": c = 5'd11;
         "E": c = 5'd12;  "C": c = 5'd13;  "X": c = 5'd14;  "D": c = 5'd15;
         "U": c = 5'd16;  "P": c = 5'd17;  "Q": c = 5'd18;  "B": c = 5'd19;
         "I": c = 5'd20;  "N": c = 5'd21;  "O": c = 5'd22;
         default: c = TYPE_W'(TYPE_COUNT);
      endcase
      return c;
   endfunction

   function automatic logic [POS_W-1:0] layout_count(input logic [TYPE_W-1:0] c);
      logic [POS_W-1:0] n;
      unique case (c)
         5'd0: n = 5'd4;   5'd1: n = 5'd17;  5'd2: n = 5'd7;   5'd3: n = 5'd5;
         5'd4: n = 5'd8;   5'd5: n = 5'd6;   5'd6: n = 5'd4;   5'd7: n = 5'd7;
         5'd8: n = 5'd8;   5'd9: n = 5'd6;   5'd10: n = 5'd8;  5'd11: n = 5'd9;
         5'd12: n = 5'd6;  5'd13: n = 5'd8;  5'd14: n = 5'd5;  5'd15: n = 5'd4;
         5'd16: n = 5'd7;  5'd17: n = 5'd9;  5'd18: n = 5'd8;  5'd19: n = 5'd4;
         5'd20: n = 5'd12; 5'd21: n = 5'd5;  5'd22: n = 5'd10;
         default: n = 5'd4;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

### hdl/itchp_layout.sv
// itchp_layout: field size of a layout slot for a type code
// depends on itchp_pkg
`default_nettype none
module itchp_layout #(
   parameter int SYMBOL_BYTES = 8
) (
   input  wire logic [itchp_pkg::TYPE_W-1:0] code,
   input  wire logic [itchp_pkg::POS_W-1:0]  pos,
   output logic      [3:0]                   size
);
   localparam logic [3:0] SB = 4'(SYMBOL_BYTES);

   always_comb begin
      size = 4'd1;
      if (pos == 5'd0 || pos == 5'd1) begin
         size = 4'd2;
      end else if (pos == 5'd2) begin
         size = 4'd6;
      end else begin
         unique case (code)
            5'd0, 5'd6: size = 4'd1;
            5'd1: begin
               unique case (pos)
                  5'd3: size = SB;
                  5'd6, 5'd15: size = 4'd4;
                  5'd9: size = 4'd2;
                  default: size = 4'd1;
               endcase
            end
            5'd2: size = (pos == 5'd3) ? SB : (pos == 5'd6) ? 4'd4 : 4'd1;
            5'd3, 5'd21: size = (pos == 5'd3) ? SB : 4'd1;
            5'd4: size = (pos == 5'd3) ? 4'd4 : (pos == 5'd4) ? SB : 4'd1;
            5'd5: size = 4'd8;
            5'd7: size = (pos == 5'd3) ? SB : (pos == 5'd5) ? 4'd1 : 4'd4;
            5'd8: size = (pos == 5'd3) ? SB : 4'd4;
            5'd9: size = (pos == 5'd3) ? SB : 4'd1;
            5'd10, 5'd11, 5'd17: begin
               unique case (pos)
                  5'd3: size = 4'd8;
                  5'd8: size = (code == 5'd17) ? 4'd8 : 4'd4;
                  5'd4: size = 4'd1;
                  5'd6: size = SB;
                  default: size = 4'd4;
               endcase
            end
            5'd12: size = (pos == 5'd4) ? 4'd4 : 4'd8;
            5'd13: begin
               unique case (pos)
                  5'd4, 5'd7: size = 4'd4;
                  5'd6: size = 4'd1;
                  default: size = 4'd8;
               endcase
            end
            5'd14: size = (pos == 5'd3) ? 4'd8 : 4'd4;
            5'd15, 5'd19: size = 4'd8;
            5'd16: size = (pos == 5'd3 || pos == 5'd4) ? 4'd8 : 4'd4;
            5'd18: begin
               unique case (pos)
                  5'd3, 5'd6: size = 4'd8;
                  5'd4: size = SB;
                  5'd5: size = 4'd4;
                  default: size = 4'd1;
               endcase
            end
            5'd20: begin
               unique case (pos)
                  5'd3, 5'd4: size = 4'd8;
                  5'd6: size = SB;
                  5'd7, 5'd8, 5'd9: size = 4'd4;
                  default: size = 4'd1;
               endcase
            end
            5'd22: begin
               unique case (pos)
                  5'd3: size = SB;
                  5'd4: size = 4'd1;
                  5'd8: size = 4'd8;
                  default: size = 4'd4;
               endcase
            end
            default: size = 4'd1;
         endcase
      end
   end
endmodule
`default_nettype wire

### hdl/itch_message_field_parser.sv
// itch_message_field_parser: framed itch byte stream to big-endian fields
// depends on itchp_pkg, itchp_layout
//
//  channel | dir | payload
//  req_    | in  | tdata data_byte, tlast buffer_end
//  rsp_    | out | tdata msg_type, field_index, field_value, field_bytes;
//          |     | tlast last_field, tuser status
//  csr_    | in  | 0 filter_enable, 1 type_mask
//
// one byte per cycle; the parse runs in the cycle of acceptance and its results
// (up to two) show on rsp_ from the next cycle out of a two-entry queue.
// req_tready is high while the queue has two free slots after this cycle's rsp_
// transfer, so a byte that makes two results holds off the next byte while both
// are queued, and a stalled consumer holds off input until the queue drains.
// synchronous reset clears control state and the queue count.
`default_nettype none
module itch_message_field_parser #(
   parameter int SYMBOL_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // buffer_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [7:0] msg_type, [11:8] field_index,
                                         // [75:12] field_value, [79:76] field_bytes
   output logic             rsp_tlast,   // last_field
   output logic [2:0]       rsp_tuser,   // [2:0] status
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [22:0] csr_wdata
);
   logic        filter_ff;
   logic [22:0] mask_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  lenhi_ff, lenhi_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [4:0]  code_ff, code_in;
   logic        skip_ff, skip_in;
   logic [4:0]  pos_ff, pos_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;

   itchp_pkg::result_type q_ff [2];
   logic [1:0]  qn_ff;
   itchp_pkg::result_type r0, r1;
   logic [1:0]  nres;

   logic [7:0]  b;
   logic        at_end, take, pop;
   logic [4:0]  lk, cnt_lay;
   logic [3:0]  fsize;
   logic [63:0] acc_sh;
   logic [15:0] left_dec;

   assign b = req_tdata;
   assign at_end = req_tlast;
   assign req_tready = (qn_ff == 2'd0) || (qn_ff == 2'd1 && rsp_tready);
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = (qn_ff != 2'd0);
   assign pop = rsp_tvalid && rsp_tready;
   assign rsp_tdata = {q_ff[0].field_bytes, q_ff[0].field_value,
                       q_ff[0].field_index, q_ff[0].msg_type};
   assign rsp_tlast = q_ff[0].last_field;
   assign rsp_tuser = q_ff[0].status;

   assign lk = itchp_pkg::type_lookup(b);
   assign cnt_lay = itchp_pkg::layout_count(code_ff);
   assign acc_sh = {acc_ff[55:0], b};
   assign left_dec = left_ff - 16'd1;

   itchp_layout #(.SYMBOL_BYTES(SYMBOL_BYTES)) u_layout (
      .code(code_ff), .pos(pos_ff), .size(fsize)
   );

   function automatic itchp_pkg::result_type stat(input logic [7:0] t,
                                                  input logic [2:0] s);
      itchp_pkg::result_type r;
      r = '0;
      r.msg_type = t;
      r.status = s;
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff; lenhi_in = lenhi_ff; left_in = left_ff;
      mtype_in = mtype_ff; code_in = code_ff; skip_in = skip_ff;
      pos_in = pos_ff; cnt_in = cnt_ff; acc_in = acc_ff;
      r0 = '0; r1 = '0; nres = 2'd0;
      unique case (phase_ff)
         itchp_pkg::PH_LEN_HI: begin
            lenhi_in = b;
            mtype_in = 8'd0;
            if (at_end) begin
               r0 = stat(8'd0, itchp_pkg::ST_INC_HEADER); nres = 2'd1;
            end else begin
               phase_in = itchp_pkg::PH_LEN_LO;
            end
         end
         itchp_pkg::PH_LEN_LO: begin
            left_in = {lenhi_ff, b};
            if ({lenhi_ff, b} == 16'd0) begin
               phase_in = itchp_pkg::PH_LEN_HI;
            end else if (at_end) begin
               r0 = stat(8'd0, itchp_pkg::ST_INC_MSG); nres = 2'd1;
               phase_in = itchp_pkg::PH_LEN_HI;
            end else begin
               phase_in = itchp_pkg::PH_TYPE;
            end
         end
         itchp_pkg::PH_TYPE: begin
            logic sk;
            logic unk;
            left_in = left_dec;
            mtype_in = b; pos_in = '0; cnt_in = '0; acc_in = '0;
            unk = (lk == 5'(itchp_pkg::TYPE_COUNT));
            sk = unk || (filter_ff && !mask_ff[lk]);
            code_in = unk ? 5'd0 : lk;
            skip_in = sk;
            if (unk) begin
               r0 = stat(b, itchp_pkg::ST_UNKNOWN); nres = 2'd1;
            end
            if (left_dec == 16'd0) begin
               phase_in = itchp_pkg::PH_LEN_HI;
               if (!sk) begin
                  r0 = stat(b, itchp_pkg::ST_SHORT); nres = 2'd1;
               end
            end else if (at_end) begin
               phase_in = itchp_pkg::PH_LEN_HI;
               if (unk) begin
                  r1 = stat(b, itchp_pkg::ST_INC_MSG); nres = 2'd2;
               end else begin
                  r0 = stat(b, itchp_pkg::ST_INC_MSG); nres = 2'd1;
               end
            end else begin
               phase_in = itchp_pkg::PH_BODY;
            end
         end
         default: begin
            logic active;
            logic emit;
            logic [4:0] npos;
            itchp_pkg::result_type st;
            left_in = left_dec;
            active = !skip_ff && (pos_ff < cnt_lay);
            emit = 1'b0;
            npos = pos_ff;
            st = '0;
            if (active) begin
               acc_in = acc_sh;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff + 4'd1 >= fsize) begin
                  emit = 1'b1;
                  r0.msg_type = mtype_ff;
                  r0.field_index = pos_ff[3:0];
                  r0.field_value = acc_sh;
                  r0.field_bytes = fsize;
                  r0.last_field = (pos_ff + 5'd1 == cnt_lay);
                  r0.status = itchp_pkg::ST_FIELD;
                  npos = pos_ff + 5'd1;
                  pos_in = npos;
                  cnt_in = '0;
                  acc_in = '0;
               end
            end
            nres = {1'b0, emit};
            if (left_dec == 16'd0) begin
               phase_in = itchp_pkg::PH_LEN_HI;
               if (!skip_ff && npos < cnt_lay) begin
                  st = stat(mtype_ff, itchp_pkg::ST_SHORT);
                  nres = nres + 2'd1;
               end
            end else if (at_end) begin
               phase_in = itchp_pkg::PH_LEN_HI;
               st = stat(mtype_ff, itchp_pkg::ST_INC_MSG);
               nres = nres + 2'd1;
            end
            if (emit) r1 = st;
            else r0 = st;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= 1'b0; mask_ff <= 23'h7FFFFF;
         phase_ff <= itchp_pkg::PH_LEN_HI; lenhi_ff <= '0; left_ff <= '0;
         mtype_ff <= '0; code_ff <= '0; skip_ff <= 1'b0; pos_ff <= '0;
         cnt_ff <= '0; acc_ff <= '0; qn_ff <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == itchp_pkg::CFG_MASK) mask_ff <= csr_wdata;
            else filter_ff <= csr_wdata[0];
         end
         if (take) begin
            phase_ff <= phase_in; lenhi_ff <= lenhi_in; left_ff <= left_in;
            mtype_ff <= mtype_in; code_ff <= code_in; skip_ff <= skip_in;
            pos_ff <= pos_in; cnt_ff <= cnt_in; acc_ff <= acc_in;
         end
         qn_ff <= qn_ff - {1'b0, pop} + (take ? nres : 2'd0);
      end
   end

   // queue payload: a byte is only taken when the queue empties this cycle,
   // so new results always fill from the head
   always_ff @(posedge clock) begin
      if (take && nres != 2'd0) begin
         q_ff[0] <= r0;
         q_ff[1] <= r1;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
   end
endmodule
`default_nettype wire

### hdl/itchp_checker.sv
// itchp_checker: port-level checks for itch_message_field_parser
// bound to the top level, depends on itchp_pkg
`default_nettype none
module itchp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [2:0]  rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transfer dropped while stalled");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= itchp_pkg::ST_SHORT)
      else $error("bad status");
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != itchp_pkg::ST_FIELD
         |-> rsp_tdata[79:8] == 72'd0 && !rsp_tlast)
      else $error("status result carries field data");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input held off with nothing queued");
endmodule

bind itch_message_field_parser itchp_checker u_itchp_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
);
`default_nettype wire

### sim/tb.sv
// tb: self-checking bench for itch_message_field_parser
// depends on itchp_pkg and the parser rtl; predicts fields per byte and checks rsp transfers
`default_nettype none
module tb;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic rsp_tlast;
   logic [2:0] rsp_tuser;
   logic csr_we = 0;
   logic csr_index = 0;
   logic [22:0] csr_wdata = '0;

   itch_message_field_parser uut (.*);

   always #2 clock = ~clock;

   string type_chars = "SRHYLVWKJhAFECXDUPQBINO";
   int layout_len[23] = '{4, 17, 7, 5, 8, 6, 4, 7, 8, 6, 8, 9,
                          6, 8, 5, 4, 7, 9, 8, 4, 12, 5, 10};
   int layout_sizes[23][17] = '{
      '{2,2,6,1,0,0,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,1,1,4,1,1,2,1,1,1,1,1,4,1},
      '{2,2,6,8,1,1,4,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,1,0,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,4,8,1,1,1,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,8,8,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,1,0,0,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,4,1,4,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,4,4,4,4,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,1,1,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,1,4,8,4,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,1,4,8,4,4,0,0,0,0,0,0,0,0},
      '{2,2,6,8,4,8,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,4,8,1,4,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,4,0,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,0,0,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,8,4,4,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,1,4,8,4,8,0,0,0,0,0,0,0,0},
      '{2,2,6,8,8,4,8,1,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,0,0,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,8,1,8,4,4,4,1,1,0,0,0,0,0},
      '{2,2,6,8,1,0,0,0,0,0,0,0,0,0,0,0,0},
      '{2,2,6,8,1,4,4,4,8,4,4,0,0,0,0,0,0}};

   // predictor state
   logic        filt_en = 0;
   logic [22:0] filt_mask = 23'h7FFFFF;
   logic [1:0]  phase = itchp_pkg::PH_LEN_HI;
   logic [7:0]  len_hi = 0;
   logic [15:0] remaining = 0;
   logic [7:0]  cur_type = 0;
   int          cur_code = 0;
   logic        dropping = 0;
   int          fpos = 0;
   int          fcount = 0;
   logic [63:0] acc = 0;

   itchp_pkg::result_type expected_fields[$];
   int errors = 0;
   bit quiet = 0;
   int stall_left = 0;

   function automatic itchp_pkg::result_type mk(logic [7:0] t, int idx, logic [63:0] v,
                                                int nb, bit lst, logic [2:0] st);
      itchp_pkg::result_type r;
      r.msg_type = t; r.field_index = idx[3:0]; r.field_value = v;
      r.field_bytes = nb[3:0]; r.last_field = lst; r.status = st;
      return r;
   endfunction

   function automatic void queue_result(itchp_pkg::result_type r);
      expected_fields = {expected_fields, r};
   endfunction

   task automatic predict_byte(logic [7:0] b, bit at_end);
      int code, cnt, sz;
      code = 23;
      if (phase == itchp_pkg::PH_LEN_HI) begin
         len_hi = b;
         cur_type = 0;
         if (at_end) queue_result(mk(0, 0, 0, 0, 0, itchp_pkg::ST_INC_HEADER));
         else phase = itchp_pkg::PH_LEN_LO;
         return;
      end
      if (phase == itchp_pkg::PH_LEN_LO) begin
         remaining = {len_hi, b};
         if (remaining == 0) phase = itchp_pkg::PH_LEN_HI;
         else if (at_end) begin
            queue_result(mk(0, 0, 0, 0, 0, itchp_pkg::ST_INC_MSG));
            phase = itchp_pkg::PH_LEN_HI;
         end else phase = itchp_pkg::PH_TYPE;
         return;
      end
      remaining = remaining - 1;
      if (phase == itchp_pkg::PH_TYPE) begin
         for (int i = 0; i < 23; i++)
            if (code == 23 && type_chars[i] == b) code = i;
         cur_type = b; fpos = 0; fcount = 0; acc = 0;
         if (code == 23) begin
            cur_code = 0; dropping = 1;
            queue_result(mk(b, 0, 0, 0, 0, itchp_pkg::ST_UNKNOWN));
         end else begin
            cur_code = code;
            dropping = filt_en && !filt_mask[code];
         end
         if (remaining == 0) begin
            if (!dropping) queue_result(mk(b, 0, 0, 0, 0, itchp_pkg::ST_SHORT));
            phase = itchp_pkg::PH_LEN_HI;
         end else if (at_end) begin
            queue_result(mk(b, 0, 0, 0, 0, itchp_pkg::ST_INC_MSG));
            phase = itchp_pkg::PH_LEN_HI;
         end else phase = itchp_pkg::PH_BODY;
         return;
      end
      cnt = layout_len[cur_code];
      if (!dropping && fpos < cnt) begin
         sz = layout_sizes[cur_code][fpos];
         acc = {acc[55:0], b};
         fcount++;
         if (fcount >= sz) begin
            queue_result(mk(cur_type, fpos, acc, sz, fpos + 1 == cnt, itchp_pkg::ST_FIELD));
            fpos++; fcount = 0; acc = 0;
         end
      end
      if (remaining == 0) begin
         if (!dropping && fpos < cnt)
            queue_result(mk(cur_type, 0, 0, 0, 0, itchp_pkg::ST_SHORT));
         phase = itchp_pkg::PH_LEN_HI;
      end else if (at_end) begin
         queue_result(mk(cur_type, 0, 0, 0, 0, itchp_pkg::ST_INC_MSG));
         phase = itchp_pkg::PH_LEN_HI;
      end
   endtask

   // result-side stalls in random bursts of rsp_tready low
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 0;
         stall_left = $urandom_range(0, 8);
      end else rsp_tready <= 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         itchp_pkg::result_type got, want;
         got.msg_type = rsp_tdata[7:0];
         got.field_index = rsp_tdata[11:8];
         got.field_value = rsp_tdata[75:12];
         got.field_bytes = rsp_tdata[79:76];
         got.last_field = rsp_tlast;
         got.status = rsp_tuser;
         if (expected_fields.size() == 0) begin
            $error("unexpected transfer %h", got);
            errors++;
         end else begin
            want = expected_fields.pop_front();
            if (got.msg_type !== want.msg_type) begin
               $error("msg_type exp %h got %h", want.msg_type, got.msg_type); errors++;
            end
            if (got.field_index !== want.field_index) begin
               $error("field_index exp %0d got %0d", want.field_index, got.field_index);
               errors++;
            end
            if (got.field_value !== want.field_value) begin
               $error("field_value exp %h got %h", want.field_value, got.field_value);
               errors++;
            end
            if (got.field_bytes !== want.field_bytes) begin
               $error("field_bytes exp %0d got %0d", want.field_bytes, got.field_bytes);
               errors++;
            end
            if (got.last_field !== want.last_field) begin
               $error("last_field exp %0d got %0d", want.last_field, got.last_field);
               errors++;
            end
            if (got.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, got.status); errors++;
            end
         end
      end
   end

   // ready is sampled at the falling edge, where it equals its value at the next rise
   task automatic send_byte(logic [7:0] b, bit at_end = 0);
      int gap;
      bit ok;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      req_tlast <= at_end;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      predict_byte(b, at_end);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [22:0] v);
      drain();
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      if (idx == itchp_pkg::CFG_MASK) filt_mask = v; else filt_en = v[0];
   endtask

   // well-formed frame; len_adj shifts length off the layout, cut ends buffer early
   task automatic send_frame(logic [7:0] t, int len_adj, int cut);
      int code, len, total;
      code = 23;
      for (int i = 0; i < 23; i++) if (code == 23 && type_chars[i] == t) code = i;
      len = 1;
      if (code < 23) for (int i = 0; i < layout_len[code]; i++) len += layout_sizes[code][i];
      else len = $urandom_range(1, 6);
      len += len_adj;
      if (len < 1) len = 1;
      total = len + 2;
      send_byte(len[15:8], cut == 1);
      if (cut == 1) return;
      send_byte(len[7:0], cut == 2);
      if (cut == 2) return;
      send_byte(t, cut == 3);
      if (cut == 3) return;
      for (int i = 3; i < total; i++) begin
         send_byte(8'($urandom), cut == i + 1 && i + 1 < total);
         if (cut == i + 1 && i + 1 < total) return;
      end
   endtask

   task automatic test_directed();
      send_frame("S", 2, 0);                      // long frame
      send_frame("E", -32, 0);                    // type byte only
      send_frame("D", -3, 0);                     // ends inside a field
      send_frame("U", 0, 7);                      // buffer ends on a field boundary
      send_frame("Z", 0, 0);                      // unknown type
      send_byte(8'h00); send_byte(8'h00);         // empty frame
      send_byte(8'hFF, 1);                        // end in header
      send_byte(8'hFF); send_byte(8'hFF, 1);      // end after length
      send_byte(8'h00); send_byte(8'h01); send_byte("S"); // type only
   endtask

   // one full frame per type in full_types; W, B and N share the layouts of S, D and Y, and A is not sent
   task automatic test_all_types();
      string full_types;
      full_types = "SRHYLVKJhFECXDUPQIO";
      for (int i = 0; i < full_types.len(); i++) send_frame(full_types[i], 0, 0);
   endtask

   task automatic test_filter();
      write_csr(itchp_pkg::CFG_FILTER, 23'd1);
      write_csr(itchp_pkg::CFG_MASK, 23'h0);
      send_frame("S", -100, 0);
      send_frame("D", 0, 5);
      write_csr(itchp_pkg::CFG_MASK, 23'h555555);
      for (int i = 0; i < 23; i++) send_frame(type_chars[i], -100, 0);
      write_csr(itchp_pkg::CFG_FILTER, 23'd0);
   endtask

   task automatic test_random(int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 1) == 0) send_frame(type_chars[$urandom_range(0, 22)], -100, 0);
         else send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_all_types();
      drain();   // sender holds off until all results are in
      test_filter();
      quiet = 1;
      test_random(8);
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire

### files.f
hdl/itchp_pkg.sv
hdl/itchp_layout.sv
hdl/itch_message_field_parser.sv
hdl/itchp_checker.sv
sim/tb.sv
